// ===== src/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the table linear interpolator: field widths,
// op codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

  localparam int OP_W    = 2;
  localparam int PIDX_W  = 6;
  localparam int SLOT_W  = 10;
  localparam int VAL_W   = 32;
  localparam int TEMP_W  = 24;
  localparam int PC_W    = 7;
  localparam int RES_W   = 31;

  localparam int DIFF_W  = TEMP_W + 1;
  localparam int PROD_W  = VAL_W + DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int NUM2_W  = SUM_W + 2;
  localparam int NUM_W   = SUM_W;
  localparam int DEN_W   = DIFF_W + 1;
  localparam int REM_W   = DEN_W + RES_W;
  localparam int QCNT_W  = 5;
  localparam int DIV_STEPS = RES_W;

  localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};
  localparam logic [PC_W-1:0]  PC_RESET = PC_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_TEMP  = 2'd0,
    OP_LOAD_VALUE = 2'd1,
    OP_QUERY      = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH_LO,
    S_FETCH_HI,
    S_CAPTURE,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_PREP,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic query_load;
    logic wr_grid;
    logic wr_table;
    logic scan;
    logic rd_hi;
    logic cap_lo;
    logic cap_hi;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic prep;
    logic div_go;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic skip;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

// ===== src/tli_ctrl.sv =====
// ----------------------------------------------------------------------------
// tli_ctrl
// Controller: accepts transactions, sequences scan, fetch, multiply,
// divide and result handoff for one query at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_valid,
  input  wire logic [tli_pkg::OP_W-1:0] op,
  input  wire logic                    out_free,
  input  wire tli_pkg::status_t        stat,
  output logic                         s_ready,
  output tli_pkg::cmd_t                cmd
);
  import tli_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_valid && op == OP_QUERY) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_FETCH_LO;
        end
      end
      S_FETCH_LO:  state_next = S_FETCH_HI;
      S_FETCH_HI:  state_next = S_CAPTURE;
      S_CAPTURE:   state_next = S_MUL_A;
      S_MUL_A:     state_next = S_MUL_B;
      S_MUL_B:     state_next = S_SUM;
      S_SUM:       state_next = S_PREP;
      S_PREP:      state_next = stat.skip ? S_DONE : S_DIV_START;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    s_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_ready = !rst;
        if (s_valid && !rst) begin
          unique case (op)
            OP_LOAD_TEMP:  cmd.wr_grid    = 1'b1;
            OP_LOAD_VALUE: cmd.wr_table   = 1'b1;
            OP_QUERY:      cmd.query_load = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN:      cmd.scan   = 1'b1;
      S_FETCH_LO: ;
      S_FETCH_HI: begin
        cmd.rd_hi  = 1'b1;
        cmd.cap_lo = 1'b1;
      end
      S_CAPTURE:   cmd.cap_hi = 1'b1;
      S_MUL_A:     cmd.mul_a  = 1'b1;
      S_MUL_B:     cmd.mul_b  = 1'b1;
      S_SUM:       cmd.sum    = 1'b1;
      S_PREP:      cmd.prep   = 1'b1;
      S_DIV_START: cmd.div_go = 1'b1;
      S_DIV_WAIT: ;
      S_DONE:      cmd.out_load = out_free;
      default: ;
    endcase
  end

  a_query_to_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && s_valid && op == OP_QUERY) |=> state == S_SCAN)
    else $error("query transaction did not start a scan");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (out_free && state == S_DONE))
    else $error("result loaded into a busy output register");

endmodule

`default_nettype wire

// ===== src/tli_divider.sv =====
// ----------------------------------------------------------------------------
// tli_divider
// Restoring divider, one quotient bit per cycle, with saturation of
// quotients that exceed the result width.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tli_pkg::NUM_W-1:0]   num,
  input  wire logic [tli_pkg::DEN_W-1:0]   den,
  output logic      [tli_pkg::RES_W-1:0]   quo,
  output logic                             done
);
  import tli_pkg::*;

  logic              busy;
  logic [QCNT_W-1:0] cnt;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  dsh;
  logic [NUM_W-1:0]  sat_lim;
  logic              sat;
  logic              fits;

  assign sat_lim = NUM_W'({den, {RES_W{1'b0}}});
  assign sat     = num >= sat_lim;
  assign fits    = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == QCNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= sat ? RES_MAX : '0;
      rem <= num[REM_W-1:0];
      dsh <= REM_W'(den) << (RES_W - 1);
      cnt <= QCNT_W'(DIV_STEPS);
    end else if (busy) begin
      quo <= {quo[RES_W-2:0], fits};
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      cnt <= cnt - QCNT_W'(1);
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ===== src/tli_datapath.sv =====
// ----------------------------------------------------------------------------
// tli_datapath
// Grid and value memories, grid scan, operand fetch, shared multiplier,
// rounding setup and the iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tli_datapath #(
  parameter int GRID_DEPTH  = 64,
  parameter int VALUE_SLOTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tli_pkg::cmd_t                 cmd,
  input  wire logic [tli_pkg::PC_W-1:0]      point_count,
  input  wire logic [tli_pkg::PIDX_W-1:0]    point_index,
  input  wire logic [tli_pkg::SLOT_W-1:0]    slot,
  input  wire logic [tli_pkg::VAL_W-1:0]     load_value,
  input  wire logic [tli_pkg::TEMP_W-1:0]    temperature,
  output tli_pkg::status_t                   stat,
  output logic      [tli_pkg::RES_W-1:0]     result_value,
  output logic      [tli_pkg::SLOT_W-1:0]    result_slot
);
  import tli_pkg::*;

  localparam int GW  = $clog2(GRID_DEPTH);
  localparam int NW0 = $clog2(GRID_DEPTH + 1);
  localparam int NW  = (NW0 > PC_W) ? NW0 : PC_W;
  localparam int SW  = (VALUE_SLOTS > 1) ? $clog2(VALUE_SLOTS) : 1;
  localparam int XW0 = $clog2(VALUE_SLOTS + 1);
  localparam int XW  = (XW0 > SLOT_W) ? XW0 : SLOT_W;
  localparam int TD  = GRID_DEPTH * (2 ** SW);

  logic [TEMP_W-1:0] grid_mem [GRID_DEPTH];
  logic [VAL_W-1:0]  tbl_mem  [TD];

  logic [NW-1:0] pidx_ext, pc_ext, n_next, n_eff, scan_addr, rd_idx, lo_sel;
  logic [XW-1:0] in_slot_ext, q_slot_ext;
  logic          in_pidx_ok, in_slot_ok, q_slot_ok;
  logic [TEMP_W-1:0] q_temp;
  logic [SLOT_W-1:0] q_slot;
  logic          rd_valid, scan_hit, scan_last;
  logic [GW-1:0] lo, lo_p1, grid_ra, grid_wa;
  logic [GW+SW-1:0] tbl_ra, tbl_wa;
  logic          grid_we, tbl_we;
  logic [TEMP_W-1:0] grid_q, t1, t2;
  logic signed [VAL_W-1:0]  tbl_q, v1, v2, mul_x;
  logic signed [DIFF_W-1:0] diff_a, diff_b, diff_d, mul_y, d;
  logic signed [PROD_W-1:0] prod_c, prod, acc;
  logic signed [SUM_W-1:0]  sum;
  logic          d_neg;
  logic [DIFF_W-1:0] d_abs;
  logic signed [NUM2_W-1:0] sum2, dext, num2_c;
  logic [NUM_W-1:0] num2;
  logic [DEN_W-1:0] den;
  logic          skip_c, skip;
  logic [RES_W-1:0] special_c, special, div_q;
  logic          div_done;

  // load addressing and bounds
  assign pidx_ext    = NW'(point_index);
  assign in_slot_ext = XW'(slot);
  assign in_pidx_ok  = pidx_ext < NW'(GRID_DEPTH);
  assign in_slot_ok  = in_slot_ext < XW'(VALUE_SLOTS);
  assign grid_wa     = pidx_ext[GW-1:0];
  assign tbl_wa      = {pidx_ext[GW-1:0], in_slot_ext[SW-1:0]};
  assign grid_we     = cmd.wr_grid && in_pidx_ok;
  assign tbl_we      = cmd.wr_table && in_pidx_ok && in_slot_ok;

  // points in use, clamped to [2, GRID_DEPTH]
  assign pc_ext = NW'(point_count);
  always_comb begin
    if (pc_ext < NW'(2)) begin
      n_next = NW'(2);
    end else if (pc_ext > NW'(GRID_DEPTH)) begin
      n_next = NW'(GRID_DEPTH);
    end else begin
      n_next = pc_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      q_temp <= temperature;
      q_slot <= slot;
      n_eff  <= n_next;
    end
  end

  assign q_slot_ext = XW'(q_slot);
  assign q_slot_ok  = q_slot_ext < XW'(VALUE_SLOTS);

  // scan: one grid read issued per cycle, compared in the cycle after it is issued
  assign scan_hit       = grid_q >= q_temp;
  assign scan_last      = rd_idx == n_eff - NW'(1);
  assign stat.scan_done = cmd.scan && rd_valid && (scan_hit || scan_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (cmd.query_load) begin
      rd_valid <= 1'b0;
    end else if (cmd.scan) begin
      rd_valid <= scan_addr < n_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      scan_addr <= '0;
    end else if (cmd.scan && scan_addr < n_eff) begin
      rd_idx    <= scan_addr;
      scan_addr <= scan_addr + NW'(1);
    end
  end

  always_comb begin
    if (!scan_hit) begin
      lo_sel = n_eff - NW'(2);
    end else if (rd_idx == '0) begin
      lo_sel = '0;
    end else begin
      lo_sel = rd_idx - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (stat.scan_done) begin
      lo <= lo_sel[GW-1:0];
    end
  end

  assign lo_p1   = lo + GW'(1);
  assign grid_ra = cmd.scan ? scan_addr[GW-1:0] : (cmd.rd_hi ? lo_p1 : lo);
  assign tbl_ra  = {(cmd.rd_hi ? lo_p1 : lo), q_slot_ext[SW-1:0]};

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_wa] <= temperature;
    end
    grid_q <= grid_mem[grid_ra];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= load_value;
    end
    tbl_q <= tbl_mem[tbl_ra];
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      t1 <= grid_q;
      v1 <= tbl_q;
    end
    if (cmd.cap_hi) begin
      t2 <= grid_q;
      v2 <= tbl_q;
    end
  end

  // shared multiplier: v1*(t2-T), then v2*(T-t1)
  assign diff_a = $signed({1'b0, t2}) - $signed({1'b0, q_temp});
  assign diff_b = $signed({1'b0, q_temp}) - $signed({1'b0, t1});
  assign diff_d = $signed({1'b0, t2}) - $signed({1'b0, t1});
  assign mul_x  = cmd.mul_a ? v1 : v2;
  assign mul_y  = cmd.mul_a ? diff_a : diff_b;
  assign prod_c = PROD_W'(mul_x) * PROD_W'(mul_y);

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      prod <= prod_c;
      d    <= diff_d;
    end
    if (cmd.mul_b) begin
      prod <= prod_c;
      acc  <= prod;
    end
    if (cmd.sum) begin
      sum <= SUM_W'(acc) + SUM_W'(prod);
    end
  end

  // round to nearest: (2*num + |d|) / (2*|d|), sign of d folded into num
  assign d_neg  = d[DIFF_W-1];
  assign d_abs  = d_neg ? $unsigned(-d) : $unsigned(d);
  assign sum2   = NUM2_W'(sum) <<< 1;
  assign dext   = NUM2_W'(d_abs);
  assign num2_c = d_neg ? (dext - sum2) : (sum2 + dext);

  always_comb begin
    special_c = '0;
    if (q_slot_ok && d == '0 && !v1[VAL_W-1]) begin
      special_c = v1[RES_W-1:0];
    end
  end

  assign skip_c    = !q_slot_ok || d == '0 || num2_c[NUM2_W-1];
  assign stat.skip = skip_c;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num2    <= num2_c[NUM_W-1:0];
      den     <= {d_abs, 1'b0};
      skip    <= skip_c;
      special <= special_c;
    end
  end

  tli_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (num2),
    .den   (den),
    .quo   (div_q),
    .done  (div_done)
  );

  assign stat.div_done = div_done;
  assign result_value  = skip ? special : div_q;
  assign result_slot   = q_slot;

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    stat.scan_done |-> rd_idx < n_eff)
    else $error("scan finished outside the points in use");

endmodule

`default_nettype wire

// ===== src/table_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise-linear interpolation over a loaded temperature grid and a
// per-point row of Q16.16 values, with clamping at zero and saturation.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tuser: op; tdata: loads and queries
//  m_axis   | out | m_axis_tvalid/tready   | tdata: result_value, result_slot
//  cfg      | in  | cfg_wr_en              | cfg_wr_data: point_count
//
//  A query scans the grid entries (at most the points in use, point_count held
//  to 2..64): the grid memory is read one entry a cycle, then a 31-step
//  restoring divider forms the quotient. Queries that need no division (zero
//  width, negative result, slot out of range) skip the divider. No input is
//  taken while a query is in flight; a finished result waits in the output
//  register without holding the input.
//  Reset is synchronous; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module table_linear_interpolator #(
  parameter int GRID_DEPTH  = 64,
  parameter int VALUE_SLOTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // point_index, slot, load_value, temperature
  input  wire logic [1:0]  s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // result_value, result_slot, zero pad
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data    // point_count
);
  import tli_pkg::*;

  localparam int OUT_W = 48;

  logic [PC_W-1:0]   point_count;
  logic [PIDX_W-1:0] point_index;
  logic [SLOT_W-1:0] slot;
  logic [VAL_W-1:0]  load_value;
  logic [TEMP_W-1:0] temperature;
  logic [RES_W-1:0]  result_value;
  logic [SLOT_W-1:0] result_slot;
  logic              out_free;
  cmd_t              cmd;
  status_t           stat;

  assign point_index = s_axis_tdata[5:0];
  assign slot        = s_axis_tdata[15:6];
  assign load_value  = s_axis_tdata[47:16];
  assign temperature = s_axis_tdata[71:48];

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PC_RESET;
    end else if (cfg_wr_en) begin
      point_count <= cfg_wr_data;
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= {{(OUT_W - RES_W - SLOT_W){1'b0}}, result_slot, result_value};
    end
  end

  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .op       (s_axis_tuser),
    .out_free (out_free),
    .stat     (stat),
    .s_ready  (s_axis_tready),
    .cmd      (cmd)
  );

  tli_datapath #(
    .GRID_DEPTH  (GRID_DEPTH),
    .VALUE_SLOTS (VALUE_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .point_count  (point_count),
    .point_index  (point_index),
    .slot         (slot),
    .load_value   (load_value),
    .temperature  (temperature),
    .stat         (stat),
    .result_value (result_value),
    .result_slot  (result_slot)
  );

endmodule

`default_nettype wire

// ===== test/tb_table_linear_interpolator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_table_linear_interpolator
// Self-checking bench for the table interpolator. It loads a temperature grid
// and table rows, then runs directed corner queries and random phases over
// several point-count settings. Expected results come from a scoreboard that
// mirrors the grid and table. Both stream sides idle at random, and the
// output is held off long enough to stall the input.
// ----------------------------------------------------------------------------

import tli_pkg::*;

localparam int SLOTS = 1024;
localparam int ROWS  = 64;
localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

typedef struct packed {
  logic [OP_W-1:0]   op;
  logic [PIDX_W-1:0] pidx;
  logic [SLOT_W-1:0] slot;
  logic [VAL_W-1:0]  lval;
  logic [TEMP_W-1:0] temp;
} item_t;

typedef struct packed {
  logic [RES_W-1:0]  value;
  logic [SLOT_W-1:0] slot;
} reading_t;

class interp_scoreboard;
  logic [TEMP_W-1:0]       grid_temp [ROWS];
  logic signed [VAL_W-1:0] row_value [int];
  logic [PC_W-1:0]         point_count = PC_RESET;
  reading_t                expected_q [$];
  int                      errors = 0;
  int                      checked = 0;

  function int active_points();
    if (point_count < 2) return 2;
    if (point_count > ROWS) return ROWS;
    return int'(point_count);
  endfunction

  function int interval_low(logic [TEMP_W-1:0] t);
    int n;
    int i;
    n = active_points();
    i = n;
    for (int k = n - 1; k >= 0; k--) if (grid_temp[k] >= t) i = k;
    if (i == n) return n - 2;
    if (i == 0) return 0;
    return i - 1;
  endfunction

  function bit has_rows(logic [TEMP_W-1:0] t, logic [SLOT_W-1:0] slot);
    int lo;
    lo = interval_low(t);
    return row_value.exists(lo * SLOTS + slot) && row_value.exists((lo + 1) * SLOTS + slot);
  endfunction

  function logic [RES_W-1:0] interpolate(logic [TEMP_W-1:0] t, logic [SLOT_W-1:0] slot);
    int lo;
    longint tq, t1, t2, v1, v2, span, acc, q;
    lo = interval_low(t);
    tq = longint'(t);
    t1 = longint'(grid_temp[lo]);
    t2 = longint'(grid_temp[lo + 1]);
    v1 = longint'(row_value[lo * SLOTS + slot]);
    v2 = longint'(row_value[(lo + 1) * SLOTS + slot]);
    span = t2 - t1;
    if (span == 0) return (v1 < 0) ? '0 : v1[RES_W-1:0];
    acc = v1 * (t2 - tq) + v2 * (tq - t1);
    if (span < 0) begin
      span = -span;
      acc = -acc;
    end
    acc = 2 * acc + span;
    if (acc < 0) return '0;
    q = acc / (2 * span);
    if (q > 64'sh7FFF_FFFF) return RES_MAX;
    return q[RES_W-1:0];
  endfunction

  function void note_input(item_t it);
    reading_t exp_r;
    case (it.op)
      OP_LOAD_TEMP:  grid_temp[it.pidx] = it.temp;
      OP_LOAD_VALUE: row_value[it.pidx * SLOTS + it.slot] = it.lval;
      OP_QUERY: begin
        exp_r.value = interpolate(it.temp, it.slot);
        exp_r.slot = it.slot;
        expected_q = {expected_q, exp_r};
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [47:0] d);
    reading_t exp_r;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual value %0h slot %0d",
               $time, d[30:0], d[40:31]);
      return;
    end
    exp_r = expected_q.pop_front();
    checked++;
    if (d[30:0] !== exp_r.value) begin
      errors++;
      $display("%0t: result_value mismatch, expected %0h actual %0h (slot %0d)",
               $time, exp_r.value, d[30:0], exp_r.slot);
    end
    if (d[40:31] !== exp_r.slot) begin
      errors++;
      $display("%0t: result_slot mismatch, expected %0d actual %0d",
               $time, exp_r.slot, d[40:31]);
    end
    if (d[47:41] !== '0) begin
      errors++;
      $display("%0t: pad bits mismatch, expected 0 actual %0h", $time, d[47:41]);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_table_linear_interpolator;

  localparam int SETTLE    = 160;
  localparam int LONG_HOLD = 800;
  localparam int LIMIT     = 4000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // point_index, slot, load_value, temperature
  logic [1:0]  s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // result_value, result_slot, zero pad
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;    // point_count

  interp_scoreboard sb;

  bit calm = 0;
  bit hold_request = 0;
  int send_gap_pct = 20;
  int stall_pct = 20;
  int idle_cycles = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_ignored = 0;
  int n_cfg = 0;
  logic [SLOT_W-1:0] core_slots [4] = '{10'd0, 10'd1023, 10'd341, 10'd682};

  table_linear_interpolator u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, LIMIT, sb.pending());
      $display("tb_table_linear_interpolator: errors");
      $finish;
    end
  end

  // result side: checks each transaction, stalls in random bursts
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold == 0 && hold_request) begin
        hold_request = 0;
        hold = LONG_HOLD;
      end else if (hold == 0 && !calm && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 19);
      end
      m_axis_tready <= (hold == 0);
      if (hold > 0) hold--;
    end
  end

  function automatic item_t mk(logic [OP_W-1:0] op, logic [PIDX_W-1:0] pidx,
                               logic [SLOT_W-1:0] slot, logic [VAL_W-1:0] lval,
                               logic [TEMP_W-1:0] temp);
    item_t it;
    it.op = op;
    it.pidx = pidx;
    it.slot = slot;
    it.lval = lval;
    it.temp = temp;
    return it;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return 32'($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TEMP_W-1:0] pick_temp();
    int n;
    logic [TEMP_W-1:0] a, b;
    n = sb.active_points();
    a = sb.grid_temp[0];
    b = sb.grid_temp[n-1];
    case ($urandom_range(0, 9))
      0: return sb.grid_temp[$urandom_range(0, n - 1)];
      1: return '0;
      2: return '1;
      3: return TEMP_W'($urandom);
      default: return TEMP_W'($urandom_range(a, b));
    endcase
  endfunction

  task automatic send(input item_t it);
    if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= {it.temp, it.lval, it.slot, it.pidx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(it);
    case (it.op)
      OP_QUERY: n_queries++;
      OP_UNUSED: n_ignored++;
      default: n_loads++;
    endcase
  endtask

  task automatic load_temp(input int k, input logic [TEMP_W-1:0] t);
    send(mk(OP_LOAD_TEMP, PIDX_W'(k), SLOT_W'($urandom), $urandom, t));
  endtask

  task automatic load_value(input int k, input logic [SLOT_W-1:0] s, input logic [VAL_W-1:0] v);
    send(mk(OP_LOAD_VALUE, PIDX_W'(k), s, v, TEMP_W'($urandom)));
  endtask

  task automatic query(input logic [TEMP_W-1:0] t, input logic [SLOT_W-1:0] s);
    send(mk(OP_QUERY, PIDX_W'($urandom), s, $urandom, t));
  endtask

  // random slot where both interval rows hold data, in one case of four, else one of the full slots
  task automatic query_any(input logic [TEMP_W-1:0] t);
    logic [SLOT_W-1:0] s;
    s = SLOT_W'($urandom);
    if (!sb.has_rows(t, s) || $urandom_range(0, 3) != 0) s = core_slots[$urandom_range(0, 3)];
    query(t, s);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_point_count(input logic [PC_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.point_count = v;
    n_cfg++;
  endtask

  // first two points pinned for the directed checks, last one at full scale
  task automatic load_ascending_grid();
    logic [TEMP_W:0] t;
    load_temp(0, 24'h000100);
    load_temp(1, 24'h000300);
    t = {1'b0, 24'h000300};
    for (int k = 2; k < ROWS - 1; k++) begin
      if ($urandom_range(0, 7) != 0) t = t + (TEMP_W+1)'($urandom_range(1, 24'h3_FFFF));
      if (t > 24'hFF_FF00) t = {1'b0, 24'hFF_FF00};
      load_temp(k, t[TEMP_W-1:0]);
    end
    load_temp(ROWS - 1, 24'hFF_FFFF);
  endtask

  task automatic random_phase(input int items);
    int r, n, k;
    logic [SLOT_W-1:0] s;
    logic [TEMP_W-1:0] t, a, b;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      n = sb.active_points();
      if (r < 40) begin
        query_any(pick_temp());
      end else if (r < 60) begin
        // fill one interval for a random slot, then query inside it and at one of its ends
        k = $urandom_range(0, n - 2);
        s = SLOT_W'($urandom);
        load_value(k, s, rand_value());
        load_value(k + 1, s, rand_value());
        t = TEMP_W'($urandom_range(sb.grid_temp[k], sb.grid_temp[k+1]));
        if (sb.has_rows(t, s)) query(t, s);
        else query_any(t);
        t = sb.grid_temp[k + $urandom_range(0, 1)];
        if (sb.has_rows(t, s)) query(t, s);
        else query_any(t);
      end else if (r < 75) begin
        load_value($urandom_range(0, ROWS - 1), $urandom_range(0, 9) < 5 ?
                   core_slots[$urandom_range(0, 3)] : SLOT_W'($urandom), rand_value());
      end else if (r < 87) begin
        k = $urandom_range(0, ROWS - 1);
        a = (k > 0) ? sb.grid_temp[k-1] : '0;
        b = (k < ROWS - 1) ? sb.grid_temp[k+1] : '1;
        if ($urandom_range(0, 4) == 0) t = TEMP_W'($urandom);
        else t = TEMP_W'($urandom_range(a, b));
        load_temp(k, t);
      end else if (r < 93) begin
        send(mk(OP_UNUSED, PIDX_W'($urandom), SLOT_W'($urandom), $urandom,
                TEMP_W'($urandom)));
      end else begin
        repeat (4) query_any(pick_temp());
      end
    end
  endtask

  initial begin
    logic [PC_W-1:0] counts [8];
    sb = new;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    counts = '{7'd64, 7'd0, 7'd127, 7'd17, 7'd1, 7'd65, 7'd2, 7'd64};
    counts[3] = PC_W'($urandom_range(3, 63));
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    load_ascending_grid();
    foreach (core_slots[j])
      for (int k = 0; k < ROWS; k++) load_value(k, core_slots[j], rand_value());

    // directed, two points in use: 0x100 and 0x300
    load_value(0, 7, 32'h7FFF_FFFF);
    load_value(1, 7, 32'h8000_0000);
    query(24'h000000, 7);
    query(24'hFF_FFFF, 7);
    query(24'h000100, 7);
    query(24'h000300, 1023);
    load_value(0, 9, 32'd0);
    load_value(1, 9, 32'd1);
    query(24'h000200, 9);
    query(24'h000180, 9);
    load_value(0, 8, -32'sd5);
    load_value(1, 8, 32'd100);
    load_temp(1, 24'h000100);
    query(24'h000200, 8);
    query(24'h000200, 7);
    load_temp(1, 24'h000080);
    query(24'h0000C0, 9);
    query(24'h000200, 8);
    load_temp(1, 24'h000300);
    send(mk(OP_UNUSED, '1, '1, '1, '1));
    load_temp(ROWS - 1, 24'hFF_FFFF);
    load_value(ROWS - 1, 1023, 32'h7FFF_FFFF);
    query(24'h000000, 0);

    for (int p = 0; p < 8; p++) begin
      write_point_count(counts[p]);
      send_gap_pct = (p % 3 == 1) ? 0 : 20;
      stall_pct = (p % 3 == 1) ? 0 : 25;
      if (p == 7) calm = 1;
      if (p == 3 || p == 6) load_ascending_grid();
      random_phase(25);
      if (p == 2) begin
        hold_request = 1;
        for (int i = 0; i < 12; i++) query_any(pick_temp());
      end
      random_phase(25);
    end

    drain();
    $display("run covered %0d loads, %0d queries and %0d unused-op items", n_loads, n_queries,
             n_ignored);
    $display("%0d results compared across %0d point-count settings (below 2 up to 127)",
             sb.checked, n_cfg);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_table_linear_interpolator: clean");
    end else begin
      $display("tb_table_linear_interpolator: errors");
    end
    $finish;
  end

endmodule
